// File: hdl/kmdt_pkg.sv
// ============================================================================
// kmdt_pkg
// Shared types and constants of the key matrix debounce tracker.
// ============================================================================
`default_nettype none

package kmdt_pkg;

    // Default sizing
    localparam int MAX_KEYS_DEF   = 64;
    localparam int MAX_ROWS_DEF   = 8;
    localparam int MAX_COLS_DEF   = 8;
    localparam int TIME_WIDTH_DEF = 32;

    // Fixed field widths
    localparam int ROW_W      = 3;
    localparam int COL_W      = 3;
    localparam int NOW_W      = 32;
    localparam int DEB_W      = 8;
    localparam int DIM_W      = 4;
    localparam int KEYIDX_W   = 6;
    localparam int IDX_FULL_W = 8;   // row * cols + col, cols up to 15
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int S_DATA_W   = 40;
    localparam int M_DATA_W   = 16;

    // Register reset values
    localparam logic [DEB_W-1:0] DEBOUNCE_RESET = 8'd20;
    localparam logic [DIM_W-1:0] ROWS_RESET     = 4'd8;
    localparam logic [DIM_W-1:0] COLS_RESET     = 4'd8;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS     = 2'd2;

    // Key status codes
    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_PRESSED  = 2'd1;
    localparam logic [1:0] ST_HELD     = 2'd2;
    localparam logic [1:0] ST_RELEASED = 2'd3;

    // Per-item outcome of the key update
    typedef struct packed {
        logic [1:0] status;
        logic       changed;
        logic       debounced;
    } upd_result_t;

endpackage : kmdt_pkg

`default_nettype wire

// File: hdl/kmdt_key_store.sv
// ============================================================================
// kmdt_key_store
// Per-key state memory: level, status and change time, one entry per key.
// Registered read, valid bits so unwritten entries read as the reset value,
// and a forward path for a read that meets a write of the same entry.
// ============================================================================
`default_nettype none

module kmdt_key_store #(
    parameter int MAX_KEYS   = kmdt_pkg::MAX_KEYS_DEF,
    parameter int TIME_WIDTH = kmdt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    input  wire logic                                    rd_en,
    input  wire logic [(MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1)-1:0] rd_addr,
    output logic                                         rd_level,
    output logic [1:0]                                   rd_status,
    output logic [TIME_WIDTH-1:0]                        rd_time,
    input  wire logic                                    wr_en,
    input  wire logic [(MAX_KEYS > 1 ? $clog2(MAX_KEYS) : 1)-1:0] wr_addr,
    input  wire logic                                    wr_level,
    input  wire logic [1:0]                              wr_status,
    input  wire logic [TIME_WIDTH-1:0]                   wr_time
);
    import kmdt_pkg::*;

    localparam int EW = TIME_WIDTH + 3;

    logic [EW-1:0]       mem [MAX_KEYS];
    logic [MAX_KEYS-1:0] valid_reg;
    logic [EW-1:0]       rd_data_reg;
    logic                rd_valid_reg;
    logic                fwd_hit_reg;
    logic [EW-1:0]       fwd_data_reg;
    logic [EW-1:0]       wr_data;
    logic [EW-1:0]       entry;

    assign wr_data = {wr_level, wr_status, wr_time};

    // Memory array: one write and one registered read per cycle
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_data_reg <= wr_data;
        end
    end

    // Valid bits and forward flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
                fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
            end
        end
    end

    // Newest copy of the entry: forwarded write, stored data or reset value
    always_comb begin
        if (fwd_hit_reg) begin
            entry = fwd_data_reg;
        end else if (rd_valid_reg) begin
            entry = rd_data_reg;
        end else begin
            entry = '0;
        end
    end

    assign rd_level  = entry[EW-1];
    assign rd_status = entry[EW-2:EW-3];
    assign rd_time   = entry[TIME_WIDTH-1:0];

endmodule : kmdt_key_store

`default_nettype wire

// File: hdl/kmdt_update.sv
// ============================================================================
// kmdt_update
// Debounce decision for one key: accepts a level change once the debounce
// time has passed and works out the new status.
// ============================================================================
`default_nettype none

module kmdt_update #(
    parameter int TIME_WIDTH = kmdt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                         in_range,
    input  wire logic                         pressed,
    input  wire logic [TIME_WIDTH-1:0]        now_time,
    input  wire logic [kmdt_pkg::DEB_W-1:0]   debounce_ms,
    input  wire logic                         old_level,
    input  wire logic [1:0]                   old_status,
    input  wire logic [TIME_WIDTH-1:0]        old_time,
    output logic                              new_level,
    output logic [1:0]                        new_status,
    output logic [TIME_WIDTH-1:0]             new_time,
    output kmdt_pkg::upd_result_t             result
);
    import kmdt_pkg::*;

    logic [TIME_WIDTH-1:0] elapsed;
    logic                  accept;

    // Modulo time difference against the debounce window
    assign elapsed = now_time - old_time;
    assign accept  = (pressed != old_level) &&
                     (elapsed >= TIME_WIDTH'(debounce_ms));

    // Next entry contents
    always_comb begin
        new_level  = old_level;
        new_status = old_status;
        new_time   = old_time;
        if (accept) begin
            new_level  = pressed;
            new_status = pressed ? ST_PRESSED : ST_RELEASED;
            new_time   = now_time;
        end else if (pressed && old_level) begin
            new_status = ST_HELD;
        end
    end

    // Reported fields, zero for a key outside the matrix
    always_comb begin
        result = '0;
        if (in_range) begin
            result.status    = new_status;
            result.changed   = accept;
            result.debounced = new_level;
        end
    end

endmodule : kmdt_update

`default_nettype wire

// File: hdl/key_matrix_debounce_tracker.sv
// ============================================================================
// key_matrix_debounce_tracker
// Debounces key matrix samples and tracks a press/hold/release status per key.
// ============================================================================
// Usage: each item on the s_ channel is one sample of one key (row, column,
// active-low level, millisecond time); s_tlast marks the last sample of a scan.
// Every item gives exactly one result item on the m_ channel with the key's
// index, range flag, new status, change flag, debounced level and whether any
// key changed so far in the scan; m_tlast echoes s_tlast.
// m_tvalid rises once the item has passed the read stage and the output
// register. Throughput is one item per cycle while m_tready is high: the key
// state lives in a memory read at accept and written back when the item leaves
// the read stage, with the write forwarded to a following read of the same key,
// so back-to-back samples of one key are handled without a bubble.
// Configuration (debounce time, rows, columns) is written through cfg_we,
// cfg_index and cfg_wdata while the block is idle.
// Reset: registers return to 20 ms and 8 x 8; all keys read as released and
// idle with change time 0 at once (per-key valid bits, no clearing pass).
// When m_tready is low the result holds in the output register, the item in
// the read stage waits behind it and s_tready drops until space frees up.
// ============================================================================
`default_nettype none

module key_matrix_debounce_tracker #(
    parameter int MAX_KEYS   = kmdt_pkg::MAX_KEYS_DEF,
    parameter int MAX_ROWS   = kmdt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS   = kmdt_pkg::MAX_COLS_DEF,
    parameter int TIME_WIDTH = kmdt_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // configuration write port
    input  wire logic                              cfg_we,
    input  wire logic [kmdt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [kmdt_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // sample channel
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // row[2:0], col[5:3], raw_level[6], now_ms[38:7], zero[39]
    input  wire logic [kmdt_pkg::S_DATA_W-1:0]     s_tdata,
    input  wire logic                              s_tlast,    // scan_last
    // result channel
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // key_index[5:0], in_range[6], key_status[8:7], changed[9],
    // debounced[10], any_changed[11], zero[15:12]
    output logic [kmdt_pkg::M_DATA_W-1:0]          m_tdata,
    output logic                                   m_tlast     // scan_done
);
    import kmdt_pkg::*;

    localparam int KW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int DMW = DIM_W + 1;

    // Configuration registers
    logic [DEB_W-1:0] debounce_reg;
    logic [DIM_W-1:0] rows_reg;
    logic [DIM_W-1:0] cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            rows_reg     <= ROWS_RESET;
            cols_reg     <= COLS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DEBOUNCE: debounce_reg <= cfg_wdata;
                CFG_ROWS:     rows_reg     <= cfg_wdata[DIM_W-1:0];
                CFG_COLS:     cols_reg     <= cfg_wdata[DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Input unpacking
    logic [ROW_W-1:0]      in_row;
    logic [COL_W-1:0]      in_col;
    logic                  in_pressed;
    logic [TIME_WIDTH-1:0] in_now;

    assign in_row     = s_tdata[2:0];
    assign in_col     = s_tdata[5:3];
    assign in_pressed = ~s_tdata[6];
    assign in_now     = TIME_WIDTH'(s_tdata[38:7]);

    // Matrix bounds and linear key index
    logic [DMW-1:0]        rows_eff;
    logic [DMW-1:0]        cols_eff;
    logic [IDX_FULL_W-1:0] idx_calc;
    logic                  idx_in_range;

    always_comb begin
        rows_eff = ({1'b0, rows_reg} > DMW'(MAX_ROWS)) ? DMW'(MAX_ROWS) : {1'b0, rows_reg};
        cols_eff = ({1'b0, cols_reg} > DMW'(MAX_COLS)) ? DMW'(MAX_COLS) : {1'b0, cols_reg};
        idx_calc = IDX_FULL_W'(in_row) * IDX_FULL_W'(cols_eff) + IDX_FULL_W'(in_col);
        idx_in_range = (DMW'(in_row) < rows_eff) && (DMW'(in_col) < cols_eff) &&
                       ({1'b0, idx_calc} < (IDX_FULL_W + 1)'(MAX_KEYS));
    end

    // Pipeline handshake
    logic s_accept;
    logic s1_valid_reg;
    logic s1_adv;
    logic m_tvalid_reg;

    assign s1_adv   = s1_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Read stage: sample held while the memory read completes
    logic [IDX_FULL_W-1:0] s1_idx_reg;
    logic                  s1_inr_reg;
    logic                  s1_pressed_reg;
    logic [TIME_WIDTH-1:0] s1_now_reg;
    logic                  s1_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_accept) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_idx_reg     <= idx_in_range ? idx_calc : '0;
            s1_inr_reg     <= idx_in_range;
            s1_pressed_reg <= in_pressed;
            s1_now_reg     <= in_now;
            s1_last_reg    <= s_tlast;
        end
    end

    // Key state memory
    logic                  old_level;
    logic [1:0]            old_status;
    logic [TIME_WIDTH-1:0] old_time;
    logic                  new_level;
    logic [1:0]            new_status;
    logic [TIME_WIDTH-1:0] new_time;
    logic                  wr_en;
    upd_result_t           upd_res;

    assign wr_en = s1_adv && s1_inr_reg;

    kmdt_key_store #(
        .MAX_KEYS   (MAX_KEYS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_store (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_en     (s_accept),
        .rd_addr   (idx_calc[KW-1:0]),
        .rd_level  (old_level),
        .rd_status (old_status),
        .rd_time   (old_time),
        .wr_en     (wr_en),
        .wr_addr   (s1_idx_reg[KW-1:0]),
        .wr_level  (new_level),
        .wr_status (new_status),
        .wr_time   (new_time)
    );

    kmdt_update #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_update (
        .in_range    (s1_inr_reg),
        .pressed     (s1_pressed_reg),
        .now_time    (s1_now_reg),
        .debounce_ms (debounce_reg),
        .old_level   (old_level),
        .old_status  (old_status),
        .old_time    (old_time),
        .new_level   (new_level),
        .new_status  (new_status),
        .new_time    (new_time),
        .result      (upd_res)
    );

    // Scan change tracking
    logic scan_seen_reg;
    logic any_changed;

    assign any_changed = scan_seen_reg | upd_res.changed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_seen_reg <= 1'b0;
        end else if (s1_adv) begin
            scan_seen_reg <= s1_last_reg ? 1'b0 : any_changed;
        end
    end

    // Output register
    logic [M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_adv) begin
            m_data_reg <= {4'b0000, any_changed, upd_res.debounced, upd_res.changed,
                           upd_res.status, s1_inr_reg, s1_idx_reg[KEYIDX_W-1:0]};
            m_last_reg <= s1_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule : key_matrix_debounce_tracker

`default_nettype wire

// File: tb/key_matrix_debounce_tracker_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// key_matrix_debounce_tracker_tb
// Self-checking testbench of the key matrix debounce tracker.
// ============================================================================
// A short table of directed samples runs first: matrix corners, timer wrap,
// the debounce threshold, out-of-range keys, shrunken and oversized or empty
// matrix settings, zero debounce and a write to an unused register index.
// Rows whose result is obvious carry it in the table. Every other row is
// checked against a behavioral key tracker kept in the testbench. Random
// phases follow. Each phase reprograms the block and then runs ordered
// matrix scans of bouncing keys, with some stray samples and broken scans
// mixed in. Sender gaps and receiver stalls change from phase to phase.
// ============================================================================

module key_matrix_debounce_tracker_tb;

    import kmdt_pkg::*;

    // Register index that maps to no register
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int MAX_REPORTS     = 10;

    typedef enum int {
        ROW_SAMPLE,
        ROW_CFG
    } dir_op_e;

    typedef enum int {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SINK,
        IDLE_BOTH
    } idle_mode_e;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             raw;
        logic [NOW_W-1:0] now_ms;
        logic             last;
    } key_sample_t;

    typedef struct packed {
        logic [KEYIDX_W-1:0] key_index;
        logic                in_range;
        logic [1:0]          key_status;
        logic                changed;
        logic                debounced;
        logic                any_changed;
        logic                scan_done;
    } key_result_t;

    typedef struct {
        dir_op_e              op;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DATA_W-1:0] reg_val;
        key_sample_t          smp;
        bit                   known;
        key_result_t          res;
    } dir_row_t;

    // DUT signals
    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tlast;

    // Tracker mirror: registers and per-key state
    logic [DEB_W-1:0] dbnc_reg = DEBOUNCE_RESET;
    logic [DIM_W-1:0] rows_reg = ROWS_RESET;
    logic [DIM_W-1:0] cols_reg = COLS_RESET;
    logic             key_level [MAX_KEYS_DEF];
    logic [NOW_W-1:0] key_time  [MAX_KEYS_DEF];
    logic [1:0]       key_state [MAX_KEYS_DEF];
    logic             scan_seen = 1'b0;

    key_result_t pending_results [$];
    dir_row_t    dir_tab [$];
    idle_mode_e  idle_mode = IDLE_NONE;
    int          fail_cnt  = 0;

    key_matrix_debounce_tracker u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // 100 MHz clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Clamp a matrix dimension to the physical maximum
    function automatic int eff_dim(input logic [DIM_W-1:0] v, input int lim);
        return (int'(v) > lim) ? lim : int'(v);
    endfunction

    // Debounce update of one key sample, advances the mirror state
    function automatic key_result_t compute_key_update(input key_sample_t smp);
        key_result_t      r;
        int               rows_n;
        int               cols_n;
        int               idx;
        logic             pressed;
        logic [NOW_W-1:0] elapsed;
        r       = '0;
        rows_n  = eff_dim(rows_reg, MAX_ROWS_DEF);
        cols_n  = eff_dim(cols_reg, MAX_COLS_DEF);
        pressed = ~smp.raw;
        idx     = 0;
        if (int'(smp.row) < rows_n && int'(smp.col) < cols_n) begin
            idx = int'(smp.row) * cols_n + int'(smp.col);
            if (idx < MAX_KEYS_DEF) begin
                r.in_range = 1'b1;
            end
        end
        if (r.in_range) begin
            elapsed = smp.now_ms - key_time[idx];
            if (pressed != key_level[idx] && elapsed >= NOW_W'(dbnc_reg)) begin
                key_time[idx]  = smp.now_ms;
                key_level[idx] = pressed;
                key_state[idx] = pressed ? ST_PRESSED : ST_RELEASED;
                r.changed      = 1'b1;
                scan_seen      = 1'b1;
            end else if (pressed && key_level[idx]) begin
                key_state[idx] = ST_HELD;
            end
            r.key_index  = KEYIDX_W'(idx);
            r.key_status = key_state[idx];
            r.debounced  = key_level[idx];
        end
        r.any_changed = scan_seen;
        r.scan_done   = smp.last;
        if (smp.last) begin
            scan_seen = 1'b0;
        end
        return r;
    endfunction

    function automatic key_sample_t mk_smp(input int row, input int col, input bit raw,
                                           input logic [NOW_W-1:0] now, input bit last);
        key_sample_t s;
        s.row    = ROW_W'(row);
        s.col    = COL_W'(col);
        s.raw    = raw;
        s.now_ms = now;
        s.last   = last;
        return s;
    endfunction

    // Table rows: sample checked by the tracker mirror
    function automatic dir_row_t row_smp(input int row, input int col, input bit raw,
                                         input logic [NOW_W-1:0] now, input bit last);
        dir_row_t d;
        d.op      = ROW_SAMPLE;
        d.reg_idx = '0;
        d.reg_val = '0;
        d.smp     = mk_smp(row, col, raw, now, last);
        d.known   = 1'b0;
        d.res     = '0;
        return d;
    endfunction

    // Table rows: sample with its result typed in
    function automatic dir_row_t row_known(input int row, input int col, input bit raw,
                                           input logic [NOW_W-1:0] now, input bit last,
                                           input int idx, input bit inr, input logic [1:0] st,
                                           input bit chg, input bit deb, input bit any);
        dir_row_t d;
        d = row_smp(row, col, raw, now, last);
        d.known = 1'b1;
        d.res   = {KEYIDX_W'(idx), inr, st, chg, deb, any, last};
        return d;
    endfunction

    // Table rows: register write
    function automatic dir_row_t row_cfg(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] val);
        dir_row_t d;
        d         = row_smp(0, 0, 1'b1, '0, 1'b0);
        d.op      = ROW_CFG;
        d.reg_idx = idx;
        d.reg_val = val;
        return d;
    endfunction

    // Offer one sample, wait for its accept, queue its expected result
    task automatic send_sample(input key_sample_t smp, input bit known,
                               input key_result_t known_res);
        key_result_t pred;
        int          gap_pct;
        gap_pct = (idle_mode == IDLE_SRC) ? 59 : (idle_mode == IDLE_BOTH) ? 25 : 0;
        cfg_we <= 1'b0;
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, smp.now_ms, smp.raw, smp.col, smp.row};
        s_tlast  <= smp.last;
        do @(posedge aclk); while (!s_tready);
        pred = compute_key_update(smp);
        pending_results.push_back(known ? known_res : pred);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        cfg_we   <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    // One register write; cfg_we is lowered by the next send or drain
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE: dbnc_reg = val;
            CFG_ROWS:     rows_reg = val[DIM_W-1:0];
            CFG_COLS:     cols_reg = val[DIM_W-1:0];
            default: begin
            end
        endcase
    endtask

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) begin
            return '0;
        end else if (r == 9) begin
            return DIM_W'($urandom_range(9, 15));
        end
        return DIM_W'($urandom_range(1, 4));
    endfunction

    // Result checker and receiver stalls
    always @(posedge aclk) begin
        key_result_t got;
        key_result_t want;
        int          stall_pct;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tdata[5:0], m_tdata[6], m_tdata[8:7], m_tdata[9],
                       m_tdata[10], m_tdata[11], m_tlast};
                if (pending_results.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS) begin
                        $display("%0t: unexpected result item %h", $realtime, got);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got !== want) begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS) begin
                            $display({"%0t: mismatch idx/inr/st/chg/deb/any/done ",
                                      "exp %0d/%0d/%0d/%0d/%0d/%0d/%0d ",
                                      "got %0d/%0d/%0d/%0d/%0d/%0d/%0d"}, $realtime,
                                     want.key_index, want.in_range, want.key_status,
                                     want.changed, want.debounced, want.any_changed,
                                     want.scan_done, got.key_index, got.in_range,
                                     got.key_status, got.changed, got.debounced,
                                     got.any_changed, got.scan_done);
                        end
                    end
                end
            end
            stall_pct = (idle_mode == IDLE_SINK) ? 59 : (idle_mode == IDLE_BOTH) ? 25 : 0;
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Run limit
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial begin
        key_sample_t      smp;
        logic [NOW_W-1:0] now_ms;
        logic [63:0]      key_down;
        int               rows_n;
        int               cols_n;
        int               scan_len;
        int               items;
        int               k;

        for (k = 0; k < MAX_KEYS_DEF; k++) begin
            key_level[k] = 1'b0;
            key_time[k]  = '0;
            key_state[k] = ST_IDLE;
        end
        key_down = '0;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table, reset settings: 20 ms debounce, 8 x 8 matrix
        dir_tab.push_back(row_known(0, 0, 1, 32'd0,  0, 0, 1, ST_IDLE,     0, 0, 0));
        dir_tab.push_back(row_known(0, 0, 0, 32'd5,  0, 0, 1, ST_IDLE,     0, 0, 0));
        dir_tab.push_back(row_known(0, 0, 0, 32'd20, 0, 0, 1, ST_PRESSED,  1, 1, 1));
        dir_tab.push_back(row_known(0, 0, 0, 32'd21, 0, 0, 1, ST_HELD,     0, 1, 1));
        dir_tab.push_back(row_known(0, 0, 1, 32'd30, 0, 0, 1, ST_HELD,     0, 1, 1));
        dir_tab.push_back(row_known(0, 0, 1, 32'd40, 1, 0, 1, ST_RELEASED, 1, 0, 1));
        // far corner key across the timer wrap
        dir_tab.push_back(row_known(7, 7, 1, 32'd0,         0, 63, 1, ST_IDLE,     0, 0, 0));
        dir_tab.push_back(row_known(7, 7, 0, 32'hFFFF_FFFF, 0, 63, 1, ST_PRESSED,  1, 1, 1));
        dir_tab.push_back(row_known(7, 7, 1, 32'h0000_0010, 0, 63, 1, ST_PRESSED,  0, 1, 1));
        dir_tab.push_back(row_known(7, 7, 1, 32'h0000_0013, 1, 63, 1, ST_RELEASED, 1, 0, 1));
        // 2 x 3 matrix, upper data bits ignored
        dir_tab.push_back(row_cfg(CFG_ROWS, 8'hA2));
        dir_tab.push_back(row_cfg(CFG_COLS, 8'h53));
        dir_tab.push_back(row_known(2, 0, 0, 32'd100, 0, 0, 0, ST_IDLE,    0, 0, 0));
        dir_tab.push_back(row_known(1, 3, 0, 32'd100, 0, 0, 0, ST_IDLE,    0, 0, 0));
        dir_tab.push_back(row_known(1, 2, 0, 32'd100, 0, 5, 1, ST_PRESSED, 1, 1, 1));
        dir_tab.push_back(row_known(7, 7, 1, 32'd200, 1, 0, 0, ST_IDLE,    0, 0, 1));
        // zero debounce; write to the unused index must not disturb anything
        dir_tab.push_back(row_cfg(CFG_DEBOUNCE, 8'h00));
        dir_tab.push_back(row_cfg(CFG_UNUSED, 8'hFF));
        dir_tab.push_back(row_known(1, 2, 1, 32'd100, 0, 5, 1, ST_RELEASED, 1, 0, 1));
        // empty matrix: nothing in range, scan still closes
        dir_tab.push_back(row_cfg(CFG_ROWS, 8'hF0));
        dir_tab.push_back(row_known(0, 0, 0, 32'd300, 1, 0, 0, ST_IDLE, 0, 0, 1));
        // oversized settings clamp to 8 x 8, longest debounce
        dir_tab.push_back(row_cfg(CFG_ROWS, 8'h0F));
        dir_tab.push_back(row_cfg(CFG_COLS, 8'h09));
        dir_tab.push_back(row_cfg(CFG_DEBOUNCE, 8'hFF));
        dir_tab.push_back(row_smp(7, 7, 0, 32'h0000_1000, 0));
        dir_tab.push_back(row_smp(7, 7, 1, 32'h0000_1010, 0));
        dir_tab.push_back(row_smp(6, 5, 0, 32'h0000_1100, 0));
        dir_tab.push_back(row_smp(0, 0, 0, 32'h0000_2000, 1));

        foreach (dir_tab[i]) begin
            if (dir_tab[i].op == ROW_CFG) begin
                drain_results();
                write_reg(dir_tab[i].reg_idx, dir_tab[i].reg_val);
            end else begin
                send_sample(dir_tab[i].smp, dir_tab[i].known, dir_tab[i].res);
            end
        end

        // Random phases: new settings and idle pattern each time
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0: begin
                    write_reg(CFG_DEBOUNCE, 8'd0);
                    write_reg(CFG_ROWS, 8'h38);
                    write_reg(CFG_COLS, 8'hC8);
                end
                1: begin
                    write_reg(CFG_DEBOUNCE, 8'd255);
                    write_reg(CFG_ROWS, 8'h01);
                    write_reg(CFG_COLS, 8'h01);
                end
                2: begin
                    write_reg(CFG_DEBOUNCE, 8'd20);
                    write_reg(CFG_ROWS, 8'h08);
                    write_reg(CFG_COLS, 8'h01);
                end
                3: begin
                    write_reg(CFG_DEBOUNCE, 8'd1);
                    write_reg(CFG_ROWS, 8'h01);
                    write_reg(CFG_COLS, 8'h08);
                end
                default: begin
                    write_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(0, 40)));
                    write_reg(CFG_ROWS, {4'($urandom_range(15)), pick_dim()});
                    write_reg(CFG_COLS, {4'($urandom_range(15)), pick_dim()});
                end
            endcase
            idle_mode = idle_mode_e'(phase % 4);
            now_ms    = (phase == 5) ? 32'hFFFF_FF80 : NOW_W'($urandom());
            rows_n    = eff_dim(rows_reg, MAX_ROWS_DEF);
            cols_n    = eff_dim(cols_reg, MAX_COLS_DEF);
            items     = 0;

            while (items < ITEMS_PER_PHASE) begin
                // keys change physical state between scans
                for (k = 0; k < MAX_KEYS_DEF; k++) begin
                    if ($urandom_range(99) < 20) begin
                        key_down[k] = ~key_down[k];
                    end
                end
                now_ms += NOW_W'($urandom_range(0, int'(dbnc_reg) / 2 + 4));
                scan_len = (rows_n == 0 || cols_n == 0) ? $urandom_range(1, 8)
                                                         : rows_n * cols_n;
                for (int slot = 0; slot < scan_len; slot++) begin
                    now_ms += NOW_W'($urandom_range(0, 3));
                    if (rows_n == 0 || cols_n == 0) begin
                        k   = $urandom_range(0, MAX_KEYS_DEF - 1);
                        smp = mk_smp(k / 8, k % 8, 1'($urandom_range(1)), now_ms, 1'b0);
                    end else begin
                        k   = slot;
                        smp = mk_smp(slot / cols_n, slot % cols_n,
                                     ~(key_down[k] ^ ($urandom_range(99) < 15)),
                                     now_ms, 1'b0);
                    end
                    smp.last = (slot == scan_len - 1);
                    // stray samples and broken scans
                    if ($urandom_range(99) < 10) begin
                        smp.row = ROW_W'($urandom_range(7));
                        smp.col = COL_W'($urandom_range(7));
                        smp.raw = 1'($urandom_range(1));
                    end
                    if ($urandom_range(99) < 3) begin
                        smp.now_ms = NOW_W'($urandom());
                    end
                    if ($urandom_range(99) < 4) begin
                        smp.last = ~smp.last;
                    end
                    send_sample(smp, 1'b0, '0);
                    items++;
                end
            end
        end

        // Wind down
        drain_results();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
